// ===== rtl/cfwb_pkg.sv =====
// Shared constants and types for the CCD full-well blooming unit.
// No dependencies; imported by every other file in rtl/.
package cfwb_pkg;

   localparam int ROWS      = 64;                 // pixels per column, 2..64
   localparam int ADDR_W    = $clog2(ROWS);       // column store address
   localparam int CNT_W     = $clog2(ROWS + 1);   // fill count, holds ROWS itself
   localparam int DATA_W    = 32;                 // Q24.8 charge
   localparam int ROW_NUM_W = 6;                  // row number field on the result
   localparam int QDEPTH    = 4;                  // command queue depth, power of two
   localparam int QPTR_W    = $clog2(QDEPTH);

   localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd230400000;

   // One classified input item, front to back.
   typedef struct packed {
      logic [DATA_W-1:0] charge;
      logic [ADDR_W-1:0] addr;     // store slot, valid when wr set
      logic              wr;       // item is stored (not dropped)
      logic              last;     // end of column: bloom and emit
      logic              dropped;  // column has lost pixels so far
      logic [CNT_W-1:0]  count;    // pixels stored including this one
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== rtl/ccd_full_well_blooming_unit.sv =====
// Top level of the CCD full-well blooming unit: limit register and wiring of
// front end, command queue and back end. Depends on cfwb_pkg and the cfwb_ modules.
//
// The unit takes one CCD column, a pixel per item, until an item with tlast
// set, then blooms it and sends the whole column back, one item per pixel in
// row order, tlast on the final one. Charges are unsigned Q24.8 electrons.
// A pixel above the full-well limit keeps the limit (plus one LSB if the
// excess is odd) and sends half its excess down and half up the column; a
// neighbour pushed over the limit is clipped to it and passes its own excess
// on, until the walk reaches a pixel below the limit or the column edge,
// where the charge is lost. Sums saturate at all ones. Pixels beyond 64 rows
// are dropped and every result of that column has tuser set. Loading runs
// at one item per cycle through a four-deep command queue. After the end
// item the back-end sequencer owns the single column store: a row is a read,
// a check and a step on; a walk step is a registered memory read, then
// add/clip/write; S_UP0 turns from the down to the up walk; a result is a
// read, then a result register load. A blooming pixel of an n-pixel column
// takes at most n - 1 walk steps. Input items are held off only once the
// queue fills meanwhile. The result register lets the next read proceed
// while a result waits. The limit is to be written via csr_we/csr_wdata
// while the unit is idle, not enforced here; it resets to 900000 electrons.
module ccd_full_well_blooming_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_charge
   input  logic        req_tlast,   // end_of_column
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] pixel_charge_out, [37:32] row_number, [39:38] zero
   output logic        rsp_tlast,   // last_of_column
   output logic        rsp_tuser,   // input_dropped
   // configuration
   input  logic        csr_we,
   input  logic [31:0] csr_wdata    // full_well_limit
);
   import cfwb_pkg::*;

   logic [DATA_W-1:0]    limit_ff;
   q_status_type         q_status;
   cmd_type              front_cmd, back_cmd;
   logic                 push, pop;
   logic [DATA_W-1:0]    out_charge;
   logic [ROW_NUM_W-1:0] out_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   cfwb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .cmd        (front_cmd)
   );

   cfwb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .cmd_in   (front_cmd),
      .pop      (pop),
      .cmd_out  (back_cmd),
      .q_status (q_status)
   );

   cfwb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .limit       (limit_ff),
      .q_status    (q_status),
      .cmd         (back_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_charge  (out_charge),
      .rsp_row     (out_row),
      .rsp_last    (rsp_tlast),
      .rsp_dropped (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, out_row, out_charge};

endmodule

// ===== rtl/cfwb_front.sv =====
// Front end: accepts input items, counts the column fill and classifies
// each item as stored or dropped. Depends on cfwb_pkg.
module cfwb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cfwb_pkg::DATA_W-1:0] req_tdata,
   input  logic                        req_tlast,
   input  cfwb_pkg::q_status_type      q_status,
   output logic                        push,
   output cfwb_pkg::cmd_type           cmd
);
   import cfwb_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic             room;

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && !q_status.full;
   assign room       = (count_ff < CNT_W'(ROWS));

   always_comb begin
      cmd.charge  = req_tdata;
      cmd.addr    = count_ff[ADDR_W-1:0];
      cmd.wr      = room;
      cmd.last    = req_tlast;
      cmd.dropped = overflow_ff || !room;
      cmd.count   = room ? count_ff + CNT_W'(1) : count_ff;
      count_in    = cmd.count;
      overflow_in = cmd.dropped;
      if (req_tlast) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (push) begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

// ===== rtl/cfwb_queue.sv =====
// Short command queue between front and back ends.
// Depends on cfwb_pkg for the command type and depth.
module cfwb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cfwb_pkg::cmd_type      cmd_in,
   input  logic                   pop,
   output cfwb_pkg::cmd_type      cmd_out,
   output cfwb_pkg::q_status_type q_status
);
   import cfwb_pkg::*;

   cmd_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff;
   logic              do_push, do_pop;

   assign q_status.empty = (fill_ff == '0);
   assign q_status.full  = (fill_ff == (QPTR_W+1)'(QDEPTH));
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign cmd_out        = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + (QPTR_W+1)'(1);
            2'b01:   fill_ff <= fill_ff - (QPTR_W+1)'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

// ===== rtl/cfwb_back.sv =====
// Back end: column store, blooming sequencer and result register.
// Depends on cfwb_pkg; fed by cfwb_queue.
module cfwb_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cfwb_pkg::DATA_W-1:0]    limit,
   input  cfwb_pkg::q_status_type         q_status,
   input  cfwb_pkg::cmd_type              cmd,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cfwb_pkg::DATA_W-1:0]    rsp_charge,
   output logic [cfwb_pkg::ROW_NUM_W-1:0] rsp_row,
   output logic                           rsp_last,
   output logic                           rsp_dropped
);
   import cfwb_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ROW_RD, S_ROW_EX, S_DN_RD, S_DN_EX,
      S_UP0, S_UP_RD, S_UP_EX, S_NEXT, S_EM_RD, S_EM_EX
   } state_type;

   state_type         state_ff;
   logic [DATA_W-1:0] mem [ROWS];
   logic [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr, waddr;
   logic [DATA_W-1:0] wdata;
   logic              we;

   logic [ADDR_W-1:0] r_ff, j_ff, k_ff;
   logic [CNT_W-1:0]  n_ff;
   logic              drop_ff;
   logic [DATA_W-1:0] e_ff, half_ff;
   logic              rsp_valid_ff;

   logic [DATA_W:0]   sum;
   logic [DATA_W-1:0] sat_val, excess, half;
   logic              over, row_over, row_more, j_more, k_last;

   // walk arithmetic: saturating add of the travelling excess
   always_comb begin
      sum      = {1'b0, rd_data_ff} + {1'b0, e_ff};
      sat_val  = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
      over     = (sat_val > limit);
      row_over = (rd_data_ff > limit);
      excess   = rd_data_ff - limit;
      half     = excess >> 1;
      row_more = (CNT_W'(r_ff) + CNT_W'(1)) < n_ff;
      j_more   = (CNT_W'(j_ff) + CNT_W'(1)) < n_ff;
      k_last   = (CNT_W'(k_ff) + CNT_W'(1)) == n_ff;
   end

   assign pop = (state_ff == S_IDLE) && !q_status.empty;

   always_comb begin
      case (state_ff)
         S_ROW_RD, S_ROW_EX:                 rd_addr = r_ff;
         S_DN_RD, S_DN_EX, S_UP_RD, S_UP_EX: rd_addr = j_ff;
         default:                            rd_addr = k_ff;
      endcase
   end

   always_comb begin
      we    = 1'b0;
      waddr = j_ff;
      wdata = over ? limit : sat_val;
      case (state_ff)
         S_IDLE: begin
            we    = pop && cmd.wr;
            waddr = cmd.addr;
            wdata = cmd.charge;
         end
         S_ROW_EX: begin
            // source keeps limit plus the odd LSB, if any
            we    = row_over;
            waddr = r_ff;
            wdata = rd_data_ff - {half[DATA_W-2:0], 1'b0};
         end
         S_DN_EX, S_UP_EX: we = 1'b1;
         default:          we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (pop && cmd.last) begin
                  n_ff     <= cmd.count;
                  drop_ff  <= cmd.dropped;
                  r_ff     <= '0;
                  state_ff <= S_ROW_RD;
               end
            end
            S_ROW_RD: state_ff <= S_ROW_EX;
            S_ROW_EX: begin
               if (row_over && (half != '0)) begin
                  half_ff <= half;
                  e_ff    <= half;
                  if (row_more) begin
                     j_ff     <= r_ff + ADDR_W'(1);
                     state_ff <= S_DN_RD;
                  end else begin
                     state_ff <= S_UP0;
                  end
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_DN_RD: state_ff <= S_DN_EX;
            S_DN_EX: begin
               if (over && j_more) begin
                  e_ff     <= sat_val - limit;
                  j_ff     <= j_ff + ADDR_W'(1);
                  state_ff <= S_DN_RD;
               end else begin
                  state_ff <= S_UP0;
               end
            end
            S_UP0: begin
               if (r_ff != '0) begin
                  e_ff     <= half_ff;
                  j_ff     <= r_ff - ADDR_W'(1);
                  state_ff <= S_UP_RD;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_UP_RD: state_ff <= S_UP_EX;
            S_UP_EX: begin
               if (over && (j_ff != '0)) begin
                  e_ff     <= sat_val - limit;
                  j_ff     <= j_ff - ADDR_W'(1);
                  state_ff <= S_UP_RD;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if (row_more) begin
                  r_ff     <= r_ff + ADDR_W'(1);
                  state_ff <= S_ROW_RD;
               end else begin
                  k_ff     <= '0;
                  state_ff <= S_EM_RD;
               end
            end
            S_EM_RD: state_ff <= S_EM_EX;
            S_EM_EX: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_charge   <= rd_data_ff;
                  rsp_row      <= ROW_NUM_W'(k_ff);
                  rsp_last     <= k_last;
                  rsp_dropped  <= drop_ff;
                  if (k_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + ADDR_W'(1);
                     state_ff <= S_EM_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
